### src/rar_pkg.sv
package rar_pkg;
  localparam int IN_WIDTH_DEFAULT = 32;
  localparam int MODE_W = 3;
  localparam int RES_W = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [RES_W-1:0] n;
    logic [RES_W-1:0] d;
    logic             reduce;
    logic             zero_err;
    logic             is_less;
    logic             is_equal;
  } job_t;

  function automatic logic [RES_W-1:0] mag64(input logic [RES_W-1:0] x);
    mag64 = x[RES_W-1] ? (~x + 64'd1) : x;
  endfunction
endpackage

### src/rar_front.sv
module rar_front
  import rar_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [31:0]       num_a,
  input  logic [31:0]       den_a,
  input  logic [31:0]       num_b,
  input  logic [31:0]       den_b,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_FORM = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [MODE_W-1:0] md;
  logic signed [RES_W-1:0] na, da, nb, db;
  logic signed [RES_W-1:0] cl, cr, p3, p4;
  logic signed [RES_W-1:0] ma, mb, pr;
  job_t jr;
  logic [RES_W-1:0] n, d;

  function automatic logic signed [RES_W-1:0] sext(input logic [31:0] v);
    sext = RES_W'($signed(v[IN_WIDTH-1:0]));
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign job_valid = (state == ST_OUT);
  assign job       = jr;

  always_comb begin
    unique case (state)
      ST_MUL1: begin ma = na; mb = db; end
      default: begin ma = da; mb = nb; end
    endcase
    pr = RES_W'($signed(ma[31:0]) * $signed(mb[31:0]));
    n = '0;
    d = p4;
    if (md[2]) begin
      n = da;
      d = na;
    end else begin
      unique case (md[1:0])
        OP_ADD: n = cl + cr;
        OP_SUB: n = cl - cr;
        OP_MUL: n = p3;
        OP_DIV: begin n = cl; d = cr; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            md <= mode;
            na <= sext(num_a);
            da <= sext(den_a);
            nb <= sext(num_b);
            db <= sext(den_b);
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          cl <= pr;
          p3 <= RES_W'($signed(na[31:0]) * $signed(nb[31:0]));
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          cr <= pr;
          p4 <= RES_W'($signed(da[31:0]) * $signed(db[31:0]));
          state <= ST_FORM;
        end
        ST_FORM: begin
          jr.n <= n;
          jr.d <= d;
          jr.reduce <= ~md[2];
          jr.zero_err <= (n == '0) && (d == '0);
          jr.is_less <= $signed(cl) < $signed(cr);
          jr.is_equal <= (cl == cr);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (job_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### src/rar_queue.sv
module rar_queue
  import rar_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t mem [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wp, rp;
  logic [$clog2(QUEUE_DEPTH):0] cnt;
  logic wr, rd;

  assign wr_ready = (cnt != QUEUE_DEPTH[$clog2(QUEUE_DEPTH):0]);
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + {{$clog2(QUEUE_DEPTH){1'b0}}, wr} - {{$clog2(QUEUE_DEPTH){1'b0}}, rd};
    end
  end
endmodule

### src/rar_back.sv
module rar_back
  import rar_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] res_num,
  output logic [RES_W-1:0] res_den,
  output logic             is_less,
  output logic             is_equal,
  output logic             zero_error
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DIVN = 3'd2;
  localparam logic [2:0] ST_DIVD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam int CW = $clog2(RES_W);

  logic [2:0] state;
  job_t jr;
  logic [RES_W-1:0] ga, gb, g;
  logic [CW:0] k;
  logic [RES_W-1:0] dq, dr, dmag;
  logic [CW-1:0] bit_i;
  logic [RES_W:0] trial;
  logic [RES_W-1:0] rem_sh, q_final;

  assign job_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign res_num = jr.n;
  assign res_den = jr.d;
  assign is_less = jr.is_less;
  assign is_equal = jr.is_equal;
  assign zero_error = jr.zero_err;

  always_comb begin
    rem_sh = {dr[RES_W-2:0], dmag[bit_i]};
    trial = {dr, dmag[bit_i]} - {1'b0, g};
    q_final = {dq[RES_W-2:0], ~trial[RES_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            jr <= job;
            ga <= mag64(job.n);
            gb <= mag64(job.d);
            k <= '0;
            state <= (job.reduce && !job.zero_err) ? ST_GCD : ST_OUT;
          end
        end
        ST_GCD: begin
          // Binary (Stein) gcd, one step per cycle.
          if (ga == '0 || gb == '0) begin
            g <= (ga | gb) << k;
            dmag <= mag64(jr.n);
            dq <= '0;
            dr <= '0;
            bit_i <= CW'(RES_W - 1);
            state <= ST_DIVN;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            k <= k + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= (ga - gb) >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end
        ST_DIVN, ST_DIVD: begin
          bit_i <= bit_i - 1'b1;
          if (bit_i == '0 && state == ST_DIVN) begin
            jr.n <= jr.n[RES_W-1] ? (~q_final + 1'b1) : q_final;
            dmag <= mag64(jr.d);
            dq <= '0;
            dr <= '0;
            state <= ST_DIVD;
          end else begin
            dq <= q_final;
            dr <= trial[RES_W] ? rem_sh : trial[RES_W-1:0];
            if (bit_i == '0) begin
              jr.d <= jr.d[RES_W-1] ? (~q_final + 1'b1) : q_final;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### src/rational_arith_reduce.sv
// Flow: the front end steps through ST_MUL1, ST_MUL2 and ST_FORM to ST_OUT and
// the job then passes the queue; a reciprocal or zero-over-zero transaction goes
// straight to the back-end output. Reduction adds the gcd loop and two divides.
// Throughput: one transaction per back-end pass; the binary gcd loop and the
// bit-serial divider set it. The front end works ahead through a 2-entry queue.
// Reset: synchronous, active high, clears all control state.
module rational_arith_reduce
  import rar_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0], num_a[34:3], den_a[66:35], num_b[98:67], den_b[130:99]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[63:0], res_den[127:64], is_less[128], is_equal[129], zero_error[130]
  output logic [135:0] m_axis_tdata
);
  logic fv, fr, bv, br;
  job_t fj, bj;
  logic [RES_W-1:0] rn, rd;
  logic lt, eq, ze;

  rar_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .mode(s_axis_tdata[2:0]), .num_a(s_axis_tdata[34:3]),
    .den_a(s_axis_tdata[66:35]), .num_b(s_axis_tdata[98:67]),
    .den_b(s_axis_tdata[130:99]),
    .job_valid(fv), .job_ready(fr), .job(fj)
  );

  rar_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(bv), .rd_ready(br), .rd_data(bj)
  );

  rar_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(bv), .job_ready(br), .job(bj),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .res_num(rn), .res_den(rd), .is_less(lt), .is_equal(eq), .zero_error(ze)
  );

  assign m_axis_tdata = {5'd0, ze, eq, lt, rd, rn};
endmodule
